// File: rtl/core/crt_pkg.sv
// Shared types and codes for the chunk reassembly tracker.
package crt_pkg;

   // Command codes carried in the low bits of req_tuser.
   localparam logic [1:0] FUNC_CHUNK     = 2'd0;
   localparam logic [1:0] FUNC_RESET_ALL = 2'd1;
   localparam logic [1:0] FUNC_CLEAR_REC = 2'd2;
   localparam logic [1:0] FUNC_UNUSED    = 2'd3;

   // Result actions carried in rsp_tuser.
   localparam logic [2:0] ACT_OLD      = 3'd0;
   localparam logic [2:0] ACT_APPEND   = 3'd1;
   localparam logic [2:0] ACT_NEW      = 3'd2;
   localparam logic [2:0] ACT_RESYNC   = 3'd3;
   localparam logic [2:0] ACT_RESET    = 3'd4;
   localparam logic [2:0] ACT_OVERFLOW = 3'd5;

   // Tracking state of one path of one channel.
   typedef struct packed {
      logic [16:0] offset;
      logic [15:0] chunk;
      logic [31:0] seq;
   } entry_type;

   // One memory row holds both paths of a channel.
   typedef struct packed {
      entry_type rec;
      entry_type live;
   } row_type;

   // Unpacked request beat.
   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  channel;
      logic        recovery_path;
      logic [31:0] msg_seq;
      logic [15:0] chunk_index;
      logic [15:0] chunk_count;
      logic [15:0] payload_len;
   } req_type;

   // Result beat before packing.
   typedef struct packed {
      logic [2:0]  action;
      logic [16:0] write_offset;
      logic        message_complete;
      logic [16:0] message_length;
   } rsp_type;

endpackage

// File: rtl/core/crt_update.sv
// Per-beat decision logic: classifies one beat against its table row.
module crt_update
   import crt_pkg::*;
#(
   parameter int BUFFER_BYTES = 65536
) (
   input  req_type req,
   input  logic    chan_ok,
   input  row_type row_in,
   output logic    wr_en,
   output row_type row_out,
   output rsp_type rsp
);

   entry_type   cur;
   entry_type   upd;
   logic        is_append;
   logic        is_new;
   logic [16:0] next_off;

   always_comb begin
      cur       = req.recovery_path ? row_in.rec : row_in.live;
      is_append = (req.msg_seq == cur.seq) &&
                  (({1'b0, cur.chunk} + 17'd1) == {1'b0, req.chunk_index});
      is_new    = (req.msg_seq > cur.seq) && (req.chunk_index == 16'd1);
      next_off  = is_append ? (cur.offset + {1'b0, req.payload_len})
                            : {1'b0, req.payload_len};
   end

   always_comb begin
      wr_en   = 1'b0;
      row_out = row_in;
      upd     = cur;
      rsp     = '0;
      rsp.action = ACT_OLD;
      if (req.func == FUNC_UNUSED) begin
         rsp.action = ACT_OLD;
      end else if (!chan_ok) begin
         rsp.action = (req.func == FUNC_CHUNK) ? ACT_OLD : ACT_RESET;
      end else begin
         case (req.func)
            FUNC_RESET_ALL: begin
               wr_en      = 1'b1;
               row_out    = '0;
               rsp.action = ACT_RESET;
            end
            FUNC_CLEAR_REC: begin
               wr_en       = 1'b1;
               row_out.rec = '0;
               rsp.action  = ACT_RESET;
            end
            FUNC_CHUNK: begin
               if (req.msg_seq < cur.seq) begin
                  rsp.action = ACT_OLD;
               end else if (!is_append && !is_new) begin
                  // Resync keeps the stale chunk number and offset.
                  wr_en      = 1'b1;
                  upd.seq    = req.msg_seq;
                  rsp.action = ACT_RESYNC;
               end else if (next_off > 17'(BUFFER_BYTES)) begin
                  rsp.action = ACT_OVERFLOW;
               end else begin
                  wr_en      = 1'b1;
                  upd.seq    = req.msg_seq;
                  upd.chunk  = req.chunk_index;
                  upd.offset = next_off;
                  rsp.action           = is_append ? ACT_APPEND : ACT_NEW;
                  rsp.write_offset     = is_append ? cur.offset : 17'd0;
                  rsp.message_complete = (req.chunk_index == req.chunk_count);
                  rsp.message_length   = next_off;
               end
               if (req.recovery_path) begin
                  row_out.rec = upd;
               end else begin
                  row_out.live = upd;
               end
            end
            default: begin
               rsp.action = ACT_OLD;
            end
         endcase
      end
   end

endmodule

// File: rtl/core/chunk_reassembly_tracker.sv
// Top level of the chunk reassembly tracker with its per-channel table memory.
//
// Each request beat is a chunk header or a reset command for one feed channel.
// req_tuser carries the command code and the path select; req_tdata carries
// the channel, sequence number, chunk number, chunk count and payload length.
// Every request beat produces exactly one response beat: rsp_tuser holds the
// action taken, rsp_tdata the write offset, the completion flag and the
// assembled message length.
// The accepting edge reads the channel's row from the table memory; when the
// read stage moves on, the row is written back and the response register is
// loaded. A bypass register forwards a row written in the same cycle a later
// beat of that channel reads it: one beat is taken every cycle unless stalled.
// The table is one single-port-write memory of CHANNELS rows, each holding the
// live and the recovery path of one channel.
// After reset a clearing pass writes zero to every row, one per cycle, with
// req_tready low until the pass ends. When the receiver stalls the
// response stays in its register; the beat in the read stage waits behind it
// and req_tready drops only when both are occupied.
module chunk_reassembly_tracker
   import crt_pkg::*;
#(
   parameter int CHANNELS     = 256,
   parameter int BUFFER_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Bits from low: channel[7:0], msg_seq[39:8], chunk_index[55:40],
   // chunk_count[71:56], payload_len[87:72].
   input  logic [87:0] req_tdata,
   // Bits from low: func[1:0], recovery_path[2].
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Bits from low: write_offset[16:0], message_complete[17],
   // message_length[34:18], zero padding[39:35].
   output logic [39:0] rsp_tdata,
   // Bits from low: action[2:0].
   output logic [2:0]  rsp_tuser
);

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // The table memory: one row per channel.
   row_type mem [0:CHANNELS-1];

   req_type             req_in;
   logic [ADDR_W+7:0]   chan_ext;
   logic [ADDR_W-1:0]   rd_addr;
   logic                rd_ok;
   logic                accept;
   logic                advance;
   logic                s1_move;

   // Read stage registers.
   logic                s1_vld_ff, s1_vld_in;
   req_type             s1_req_ff;
   logic                s1_ok_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   row_type             mem_rd_ff;
   row_type             byp_ff;
   logic                byp_sel_ff;
   row_type             row_cur;

   // Update results.
   logic                upd_wr;
   row_type             upd_row;
   rsp_type             upd_rsp;

   // Response register.
   logic                rsp_vld_ff, rsp_vld_in;
   rsp_type             rsp_ff;

   // Clearing pass after reset.
   logic                clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;

   // Memory write port.
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_wa;
   row_type             mem_wd;

   assign req_in.func          = req_tuser[1:0];
   assign req_in.recovery_path = req_tuser[2];
   assign req_in.channel       = req_tdata[7:0];
   assign req_in.msg_seq       = req_tdata[39:8];
   assign req_in.chunk_index   = req_tdata[55:40];
   assign req_in.chunk_count   = req_tdata[71:56];
   assign req_in.payload_len   = req_tdata[87:72];

   assign chan_ext = {{ADDR_W{1'b0}}, req_in.channel};
   assign rd_addr  = chan_ext[ADDR_W-1:0];
   assign rd_ok    = (32'(req_in.channel) < CHANNELS);

   // The read stage moves on when the response register is free or draining.
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign s1_move    = s1_vld_ff && advance;
   assign req_tready = !clr_busy_ff && (!s1_vld_ff || advance);
   assign accept     = req_tvalid && req_tready;

   // A row written back in the accepting cycle is newer than what the memory returned.
   assign row_cur = byp_sel_ff ? byp_ff : mem_rd_ff;

   crt_update #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_update (
      .req     (s1_req_ff),
      .chan_ok (s1_ok_ff),
      .row_in  (row_cur),
      .wr_en   (upd_wr),
      .row_out (upd_row),
      .rsp     (upd_rsp)
   );

   always_comb begin
      if (clr_busy_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
         mem_wd = '0;
      end else begin
         mem_we = s1_move && upd_wr;
         mem_wa = s1_addr_ff;
         mem_wd = upd_row;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && rd_ok) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      s1_vld_in = accept ? 1'b1 : (s1_move ? 1'b0 : s1_vld_ff);
      rsp_vld_in = s1_move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);
      clr_busy_in = clr_busy_ff && (clr_ff != ADDR_W'(CHANNELS - 1));
      clr_in = clr_busy_ff ? (clr_ff + ADDR_W'(1)) : clr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_ff      <= '0;
         byp_sel_ff  <= 1'b0;
      end else begin
         s1_vld_ff   <= s1_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         clr_busy_ff <= clr_busy_in;
         clr_ff      <= clr_in;
         if (accept) begin
            byp_sel_ff <= s1_move && upd_wr && (s1_addr_ff == rd_addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff  <= req_in;
         s1_ok_ff   <= rd_ok;
         s1_addr_ff <= rd_addr;
         byp_ff     <= upd_row;
      end
      if (s1_move) begin
         rsp_ff <= upd_rsp;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_ff.action;
   assign rsp_tdata  = {5'd0, rsp_ff.message_length, rsp_ff.message_complete,
                        rsp_ff.write_offset};

endmodule

// File: rtl/core/crt_checker.sv
// Port-level assertions for the chunk reassembly tracker and their binding.
module crt_checker
   import crt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // Reset empties the pipeline and starts the clearing pass.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !req_tready))
      else $error("busy or valid right after reset");

   // Only the six defined actions are ever reported.
   a_action_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= ACT_OVERFLOW))
      else $error("undefined action");

   // Actions that store no payload carry all-zero data.
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ACT_APPEND && rsp_tuser != ACT_NEW)
         |-> (rsp_tdata == 40'd0))
      else $error("nonzero data on a dropped or command beat");

   // A new message always lands at the start of the buffer.
   a_new_at_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ACT_NEW)
         |-> (rsp_tdata[16:0] == 17'd0 && rsp_tdata[39:35] == 5'd0))
      else $error("new message with nonzero offset");

   // A stalled response beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("response changed while stalled");

endmodule

bind chunk_reassembly_tracker crt_checker u_crt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/sv/chunk_reassembly_tracker_tb.sv
// Self-checking testbench for the chunk reassembly tracker stream block.
module chunk_reassembly_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import crt_pkg::*;

   localparam int NUM_CHANNELS = 256;
   localparam int BUFFER_LIMIT = 65536;
   localparam int ENTRIES      = NUM_CHANNELS * 2;
   // A correct run of about 1550 beats with random stalls on both sides,
   // clearing pass included, stays well inside this limit.
   localparam int CYCLE_LIMIT  = 50000;
   localparam int WALK_BEATS   = 200;
   localparam int RANDOM_BEATS = 1331;
   localparam int HOT_COUNT    = 6;

   // One row of the directed stimulus table. When pinned is set the expected
   // response is typed into the row; otherwise the tracker model supplies it.
   typedef struct {
      req_type beat;
      bit      pinned;
      rsp_type want;
   } vector_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   // Tracker model state: one entry per channel and path, index {channel, path}.
   logic [31:0] last_seq    [ENTRIES];
   logic [15:0] last_chunk  [ENTRIES];
   logic [16:0] fill_offset [ENTRIES];
   // Chunk count of the message the random generator is currently sending.
   logic [15:0] planned_count [ENTRIES];

   // Responses still owed by the block, oldest first.
   rsp_type     pending_rsp[$];
   int unsigned errors = 0;
   int unsigned send_idle_pct = 27;
   int unsigned recv_idle_pct = 27;
   int unsigned cycle_count = 0;

   vector_type  directed [18];
   logic [7:0]  hot_chan [HOT_COUNT];

   chunk_reassembly_tracker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 12 ns clock period.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Applies one beat to the tracker model and returns the response it owes.
   function automatic rsp_type advance_reassembly(req_type r);
      rsp_type     res;
      int unsigned e;
      logic [16:0] succ;
      logic [16:0] woff;
      logic [17:0] next_off;
      logic        is_append;
      res = '0;
      // The unused command code is answered like a discarded chunk.
      if (r.func == FUNC_UNUSED) begin
         res.action = ACT_OLD;
         return res;
      end
      if (r.channel >= NUM_CHANNELS) begin
         res.action = (r.func == FUNC_CHUNK) ? ACT_OLD : ACT_RESET;
         return res;
      end
      if (r.func == FUNC_RESET_ALL || r.func == FUNC_CLEAR_REC) begin
         // Commands ignore the path bit: the recovery entry is always cleared,
         // the live entry only by the full sequence reset.
         for (int p = 0; p < 2; p++) begin
            if (p == 1 || r.func == FUNC_RESET_ALL) begin
               e = {r.channel, p[0]};
               last_seq[e]    = '0;
               last_chunk[e]  = '0;
               fill_offset[e] = '0;
            end
         end
         res.action = ACT_RESET;
         return res;
      end
      e = {r.channel, r.recovery_path};
      // The successor compare is one bit wider, so a stored chunk number of
      // 65535 never matches chunk 0.
      succ      = {1'b0, last_chunk[e]} + 17'd1;
      is_append = (r.msg_seq == last_seq[e]) && ({1'b0, r.chunk_index} == succ);
      if (r.msg_seq < last_seq[e]) begin
         res.action = ACT_OLD;
         return res;
      end
      if (is_append) begin
         woff     = fill_offset[e];
         next_off = {1'b0, fill_offset[e]} + {2'b00, r.payload_len};
      end else if (r.msg_seq > last_seq[e] && r.chunk_index == 16'd1) begin
         woff     = '0;
         next_off = {2'b00, r.payload_len};
      end else begin
         // Resync keeps the stale chunk number and offset.
         last_seq[e] = r.msg_seq;
         res.action  = ACT_RESYNC;
         return res;
      end
      // A chunk that would run past the buffer is dropped with no state change.
      if (next_off > BUFFER_LIMIT) begin
         res.action = ACT_OVERFLOW;
         return res;
      end
      last_seq[e]    = r.msg_seq;
      last_chunk[e]  = r.chunk_index;
      fill_offset[e] = next_off[16:0];
      res.action           = is_append ? ACT_APPEND : ACT_NEW;
      res.write_offset     = woff;
      res.message_complete = (r.chunk_index == r.chunk_count);
      res.message_length   = next_off[16:0];
      return res;
   endfunction

   function automatic vector_type mk_row(logic [1:0] f, logic [7:0] ch, logic p,
                                         logic [31:0] seq, logic [15:0] idx,
                                         logic [15:0] cnt, logic [15:0] plen,
                                         bit pinned, logic [2:0] act,
                                         logic [16:0] woff, logic done,
                                         logic [16:0] len);
      vector_type v;
      v.beat.func          = f;
      v.beat.channel       = ch;
      v.beat.recovery_path = p;
      v.beat.msg_seq       = seq;
      v.beat.chunk_index   = idx;
      v.beat.chunk_count   = cnt;
      v.beat.payload_len   = plen;
      v.pinned                = pinned;
      v.want.action           = act;
      v.want.write_offset     = woff;
      v.want.message_complete = done;
      v.want.message_length   = len;
      return v;
   endfunction

   // Mostly small payloads, with enough large ones to run into the buffer end.
   function automatic logic [15:0] payload_size();
      if ($urandom_range(99) < 80) begin
         return 16'($urandom_range(3000));
      end
      return 16'($urandom_range(65535));
   endfunction

   // Presents one request beat from a falling edge, holds it until the rising
   // edge that accepts it, books the owed response and returns on the next
   // falling edge with tvalid still high.
   task automatic send_beat(input req_type beat, input bit pinned, input rsp_type want);
      rsp_type owed;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {beat.payload_len, beat.chunk_count, beat.chunk_index,
                    beat.msg_seq, beat.channel};
      req_tuser  = {beat.recovery_path, beat.func};
      do @(posedge clock); while (!req_tready);
      // The model always runs so its tables follow the block, even when the
      // expected response is pinned by the table row.
      owed = advance_reassembly(beat);
      if (pinned) begin
         owed = want;
      end
      pending_rsp.insert(pending_rsp.size(), owed);
      @(negedge clock);
   endtask

   // Lets the block drain before the sender continues.
   task automatic drain_responses();
      req_tvalid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // The receiver stalls at random; the stall rate drops to zero during the
   // long chunk walk so that stretch runs at full rate.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Every accepted response beat is compared with the oldest owed response.
   always @(posedge clock) begin : score_rsp
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.action           = rsp_tuser;
         got.write_offset     = rsp_tdata[16:0];
         got.message_complete = rsp_tdata[17];
         got.message_length   = rsp_tdata[34:18];
         if (pending_rsp.size() == 0) begin
            $display("%0t ns: response beat expected none actual action %0d",
                     $time, got.action);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            report_field("action", want.action, got.action);
            report_field("write_offset", want.write_offset, got.write_offset);
            report_field("message_complete", want.message_complete,
                         got.message_complete);
            report_field("message_length", want.message_length, got.message_length);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("chunk_reassembly_tracker: mismatch");
      $finish;
   end

   initial begin
      req_type     beat;
      rsp_type     none;
      int unsigned kind;
      int unsigned e;
      logic [7:0]  ch;
      logic        path;

      none = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         last_seq[i]      = '0;
         last_chunk[i]    = '0;
         fill_offset[i]   = '0;
         planned_count[i] = '0;
      end
      for (int i = 0; i < HOT_COUNT; i++) begin
         hot_chan[i] = 8'($urandom_range(255));
      end

      // Directed table. Pinned rows carry a response that follows directly
      // from the row and the state it leaves behind.
      // Right after reset the zeroed entry makes chunk 1 of sequence 0 an
      // append of an empty, complete message.
      directed[0]  = mk_row(FUNC_CHUNK, 8'd0, 1'b0, 32'd0, 16'd1, 16'd1, 16'd0,
                            1'b1, ACT_APPEND, 17'd0, 1'b1, 17'd0);
      // Largest sequence number and payload start a new recovery message.
      directed[1]  = mk_row(FUNC_CHUNK, 8'd255, 1'b1, 32'hFFFF_FFFF, 16'd1, 16'd3,
                            16'hFFFF, 1'b1, ACT_NEW, 17'd0, 1'b0, 17'd65535);
      // This append lands exactly on the end of the buffer.
      directed[2]  = mk_row(FUNC_CHUNK, 8'd255, 1'b1, 32'hFFFF_FFFF, 16'd2, 16'd3,
                            16'd1, 1'b1, ACT_APPEND, 17'd65535, 1'b0, 17'd65536);
      // One byte more overflows and leaves the entry untouched.
      directed[3]  = mk_row(FUNC_CHUNK, 8'd255, 1'b1, 32'hFFFF_FFFF, 16'd3, 16'd3,
                            16'd1, 1'b1, ACT_OVERFLOW, 17'd0, 1'b0, 17'd0);
      directed[4]  = mk_row(FUNC_CHUNK, 8'd255, 1'b1, 32'hFFFF_FFFF, 16'd3, 16'd3,
                            16'd0, 1'b1, ACT_APPEND, 17'd65536, 1'b1, 17'd65536);
      // An older sequence number is discarded.
      directed[5]  = mk_row(FUNC_CHUNK, 8'd255, 1'b1, 32'd5, 16'd1, 16'd1, 16'd9,
                            1'b1, ACT_OLD, 17'd0, 1'b0, 17'd0);
      // The live path of the same channel is tracked on its own.
      directed[6]  = mk_row(FUNC_CHUNK, 8'd255, 1'b0, 32'd5, 16'd1, 16'd2, 16'd100,
                            1'b1, ACT_NEW, 17'd0, 1'b0, 17'd100);
      // Clearing the recovery path must leave the live path alone; the
      // chunk fields of a command are ignored.
      directed[7]  = mk_row(FUNC_CLEAR_REC, 8'd255, 1'b0, 32'hFFFF_FFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF, 1'b1, ACT_RESET, 17'd0, 1'b0, 17'd0);
      directed[8]  = mk_row(FUNC_CHUNK, 8'd255, 1'b1, 32'd0, 16'd1, 16'd1, 16'd7,
                            1'b0, ACT_OLD, 17'd0, 1'b0, 17'd0);
      directed[9]  = mk_row(FUNC_CHUNK, 8'd255, 1'b0, 32'd5, 16'd2, 16'd2, 16'd50,
                            1'b0, ACT_OLD, 17'd0, 1'b0, 17'd0);
      directed[10] = mk_row(FUNC_RESET_ALL, 8'd255, 1'b1, 32'hFFFF_FFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF, 1'b1, ACT_RESET, 17'd0, 1'b0, 17'd0);
      // After the full reset a newer sequence without chunk 1 resyncs.
      directed[11] = mk_row(FUNC_CHUNK, 8'd255, 1'b0, 32'd5, 16'd3, 16'd3, 16'd1,
                            1'b1, ACT_RESYNC, 17'd0, 1'b0, 17'd0);
      // Resync kept chunk 0, so chunk 1 of that sequence now counts as an append.
      directed[12] = mk_row(FUNC_CHUNK, 8'd255, 1'b0, 32'd5, 16'd1, 16'd0, 16'd10,
                            1'b0, ACT_OLD, 17'd0, 1'b0, 17'd0);
      // Same sequence, chunk out of order.
      directed[13] = mk_row(FUNC_CHUNK, 8'd255, 1'b0, 32'd5, 16'd7, 16'd7, 16'd10,
                            1'b1, ACT_RESYNC, 17'd0, 1'b0, 17'd0);
      // The unused command code changes nothing.
      directed[14] = mk_row(FUNC_UNUSED, 8'd170, 1'b1, 32'hAAAA_AAAA, 16'hAAAA,
                            16'hAAAA, 16'hAAAA, 1'b1, ACT_OLD, 17'd0, 1'b0, 17'd0);
      directed[15] = mk_row(FUNC_UNUSED, 8'd0, 1'b0, 32'd0, 16'd0, 16'd0, 16'd0,
                            1'b1, ACT_OLD, 17'd0, 1'b0, 17'd0);
      directed[16] = mk_row(FUNC_CHUNK, 8'd85, 1'b1, 32'h5555_5555, 16'd1, 16'hFFFF,
                            16'h5555, 1'b1, ACT_NEW, 17'd0, 1'b0, 17'h05555);
      directed[17] = mk_row(FUNC_CHUNK, 8'd85, 1'b1, 32'h5555_5555, 16'd2, 16'hFFFF,
                            16'hAAAA, 1'b0, ACT_OLD, 17'd0, 1'b0, 17'd0);

      // Reset is held from time zero and released on a falling edge. The
      // block then runs its table clearing pass with req_tready low.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         send_beat(directed[i].beat, directed[i].pinned, directed[i].want);
      end
      // The sender holds off until the block has answered everything.
      drain_responses();

      // Walk one recovery entry through a long message of empty chunks with
      // no idling on either side. Chunk 0 afterwards is not a successor and
      // resyncs.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      beat = '0;
      beat.func          = FUNC_CHUNK;
      beat.channel       = 8'd9;
      beat.recovery_path = 1'b1;
      beat.msg_seq       = 32'd1;
      beat.chunk_count   = 16'(WALK_BEATS);
      for (int unsigned n = 1; n <= WALK_BEATS; n++) begin
         beat.chunk_index = 16'(n);
         send_beat(beat, 1'b0, none);
      end
      beat.chunk_index = 16'd0;
      send_beat(beat, 1'b0, none);
      send_idle_pct = 27;
      recv_idle_pct = 27;

      // Random part: mostly well-formed messages on a few busy channels, the
      // rest old, broken, command and fully random beats.
      for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
         if ($urandom_range(99) == 0) begin
            drain_responses();
         end
         ch   = hot_chan[$urandom_range(HOT_COUNT - 1)];
         path = 1'($urandom_range(1));
         e    = {ch, path};
         kind = $urandom_range(99);
         beat.func          = FUNC_CHUNK;
         beat.channel       = ch;
         beat.recovery_path = path;
         beat.msg_seq       = last_seq[e];
         beat.chunk_index   = last_chunk[e] + 16'd1;
         beat.chunk_count   = planned_count[e];
         beat.payload_len   = payload_size();
         if (kind < 68) begin
            // Continue the current message; once it is complete, or on purpose
            // now and then, begin the next one with chunk 1.
            if (kind >= 55 || last_chunk[e] == 16'd0 ||
                last_chunk[e] >= planned_count[e]) begin
               planned_count[e] = 16'($urandom_range(1, 8));
               beat.msg_seq     = last_seq[e] + 32'($urandom_range(1, 3));
               beat.chunk_index = 16'd1;
               beat.chunk_count = planned_count[e];
            end
         end else if (kind < 76) begin
            beat.msg_seq = last_seq[e] - 32'($urandom_range(1, 4));
         end else if (kind < 86) begin
            // A lost or repeated chunk.
            beat.msg_seq     = last_seq[e] + 32'($urandom_range(1));
            beat.chunk_index = 16'($urandom_range(10));
         end else if (kind < 92) begin
            beat.func          = 2'($urandom_range(1, 3));
            beat.recovery_path = 1'($urandom_range(1));
            beat.msg_seq       = $urandom;
            beat.chunk_index   = 16'($urandom_range(65535));
            beat.chunk_count   = 16'($urandom_range(65535));
            beat.payload_len   = 16'($urandom_range(65535));
         end else begin
            beat.func          = 2'($urandom_range(3));
            beat.channel       = 8'($urandom_range(255));
            beat.recovery_path = 1'($urandom_range(1));
            beat.msg_seq       = $urandom;
            beat.chunk_index   = 16'($urandom_range(65535));
            beat.chunk_count   = 16'($urandom_range(65535));
            beat.payload_len   = 16'($urandom_range(65535));
         end
         send_beat(beat, 1'b0, none);
      end

      // Wait for the last responses, then keep the clock running to catch any
      // stray beat the block might still emit.
      drain_responses();
      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("chunk_reassembly_tracker: match");
      end else begin
         $display("chunk_reassembly_tracker: mismatch");
      end
      $finish;
   end

endmodule
